// ===== rtl/bcpe_pkg.sv =====
package bcpe_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_START_LOG_PRICE = 3'd0;
  localparam logic [2:0] REG_STRIKE          = 3'd1;
  localparam logic [2:0] REG_LOG_BARRIER     = 3'd2;
  localparam logic [2:0] REG_DRIFT_PER_STEP  = 3'd3;
  localparam logic [2:0] REG_VOL_PER_STEP    = 3'd4;
  localparam logic [2:0] REG_STEPS_PER_PATH  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [31:0] RST_START_LOG_PRICE = 32'd309047727;
  localparam logic [31:0] RST_STRIKE          = 32'd6553600;
  localparam logic [31:0] RST_LOG_BARRIER     = 32'd326654677;
  localparam logic [31:0] RST_DRIFT_PER_STEP  = 32'd8053;
  localparam logic [30:0] RST_VOL_PER_STEP    = 31'd848867;
  localparam logic [15:0] RST_STEPS_PER_PATH  = 16'd250;

  // Exp constants
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  localparam logic [3:0]  HORNER_N0 = 4'd9;

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic               en;
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  // floor((2^32 - 1) / n): the estimate q*R >> 32 is the quotient or one below it
  function automatic logic [31:0] recip(input logic [3:0] n);
    logic [31:0] r;
    unique case (n)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h7FFF_FFFF;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h3FFF_FFFF;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h1FFF_FFFF;
      4'd9:    r = 32'h1C71_C71C;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bcpe_if.sv =====
interface bcpe_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_sample;

  modport source (output valid, output normal_sample, input ready);
  modport sink   (input valid, input normal_sample, output ready);
endinterface

interface bcpe_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] payoff;
  logic        was_knocked_out;
  logic [63:0] plain_total;
  logic [63:0] barrier_total;
  logic [31:0] paths_done;

  modport source (output valid, output payoff, output was_knocked_out,
                  output plain_total, output barrier_total, output paths_done,
                  input ready);
  modport sink   (input valid, input payoff, input was_knocked_out,
                  input plain_total, input barrier_total, input paths_done,
                  output ready);
endinterface

// ===== rtl/bcpe_mul.sv =====
module bcpe_mul (
  input  logic               clk_i,
  input  bcpe_pkg::mul_req_t req_i,
  output logic [63:0]        prod_o
);

  logic signed [65:0] full;
  logic        [63:0] prod_q;

  assign full = req_i.a * req_i.b;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= full[63:0];
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/barrier_call_path_evaluator_unit.sv =====
// Channel   Dir  Beat payload
// smp_i     in   normal_sample (Q4.12 signed), one per path step
// res_o     out  payoff, was_knocked_out, plain_total, barrier_total, paths_done
// cfg_*     in   write enable, register index, 32-bit data
//
// A step that does not end a path runs through accept, multiply and add.
// The last step of a path adds the exp: setup states EXPY, EXPT and TSAVE,
// then 9 Horner rounds (HMUL, HREC, HFIX) on the one shared 33x33 multiplier,
// then payoff and accumulation, which waits for a free output register.
// Reset is asynchronous, active low, and loads the register defaults.
// A finished beat waits in the output register; the next sample is taken
// meanwhile, and only the accumulate cycle stalls on a full output register.
module barrier_call_path_evaluator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcpe_smp_if.sink    smp_i,
  bcpe_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_ADD    = 4'd2;
  localparam logic [3:0] S_EXPY   = 4'd3;
  localparam logic [3:0] S_EXPT   = 4'd4;
  localparam logic [3:0] S_TSAVE  = 4'd5;
  localparam logic [3:0] S_HMUL   = 4'd6;
  localparam logic [3:0] S_HREC   = 4'd7;
  localparam logic [3:0] S_HFIX   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;
  localparam logic [3:0] S_ACC    = 4'd10;

  logic [3:0] state_q, state_d;

  // Configuration
  logic [31:0] start_q, strike_q, barrier_q, drift_q;
  logic [30:0] vol_q;
  logic [15:0] steps_q;

  // Path state
  logic signed [15:0] z_q;
  logic        [15:0] step_q;
  logic        [31:0] lp_q;
  logic               knock_q;
  logic signed [7:0]  k_q;
  logic        [29:0] t_q;
  logic        [30:0] p_q;
  logic        [30:0] q_q;
  logic        [3:0]  n_q;
  logic        [31:0] pay_q;
  logic        [63:0] sum_all_q, sum_surv_q;
  logic        [31:0] paths_q;

  // Output register
  logic        out_valid_q;
  logic [31:0] out_pay_q;
  logic        out_knock_q;
  logic [63:0] out_all_q, out_surv_q;
  logic [31:0] out_paths_q;

  bcpe_pkg::mul_req_t mul_req;
  logic [63:0]        prod;

  bcpe_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Step arithmetic
  logic signed [31:0] base;
  logic signed [37:0] step_sum;
  logic signed [31:0] next_lp;
  logic               first_step, last_step, knock_d;

  assign first_step = (step_q == 16'd0);
  assign base       = first_step ? $signed(start_q) : $signed(lp_q);
  assign step_sum   = 38'(base) + 38'($signed(drift_q)) + 38'($signed(prod[47:12]));
  always_comb begin
    priority if (step_sum > 38'sd2147483647) begin
      next_lp = 32'sh7FFF_FFFF;
    end else if (step_sum < -38'sd2147483648) begin
      next_lp = 32'sh8000_0000;
    end else begin
      next_lp = step_sum[31:0];
    end
  end
  assign knock_d   = (first_step ? 1'b0 : knock_q) | (next_lp >= $signed(barrier_q));
  assign last_step = ({1'b0, step_q} + 17'd1) >= {1'b0, steps_q};

  // Horner correction: reciprocal estimate is exact or one low
  logic [30:0] est;
  logic [34:0] est_n, rem;
  logic [30:0] quot;

  assign est   = prod[62:32];
  assign est_n = 35'(est) * 35'(n_q);
  assign rem   = {4'b0, q_q} - est_n;
  assign quot  = (rem >= 35'(n_q)) ? est + 31'd1 : est;

  // Price from mantissa and exponent
  logic [7:0]  sh;
  logic [31:0] price;

  assign sh = 8'(8'sd14 - k_q);
  always_comb begin
    priority if (k_q >= 8'sd16) begin
      price = 32'hFFFF_FFFF;
    end else if (k_q == 8'sd15) begin
      price = {p_q, 1'b0};
    end else if (k_q == 8'sd14) begin
      price = {1'b0, p_q};
    end else if (sh >= 8'd32) begin
      price = 32'd0;
    end else begin
      price = {1'b0, p_q} >> sh[4:0];
    end
  end

  // Saturating accumulation
  logic [64:0] all_sum, surv_sum;
  logic [63:0] all_d, surv_d;
  logic        out_free, out_load;

  assign all_sum  = {1'b0, sum_all_q} + {33'b0, pay_q};
  assign surv_sum = {1'b0, sum_surv_q} + {33'b0, pay_q};
  assign all_d    = all_sum[64] ? '1 : all_sum[63:0];
  assign surv_d   = knock_q ? sum_surv_q : (surv_sum[64] ? '1 : surv_sum[63:0]);
  assign out_free = !out_valid_q || res_o.ready;
  assign out_load = (state_q == S_ACC) && out_free;

  // Multiplier operands per state
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      S_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {2'b0, vol_q};
        mul_req.b  = 33'(z_q);
      end
      S_EXPY: begin
        mul_req.en = 1'b1;
        mul_req.a  = {lp_q[31], lp_q};
        mul_req.b  = {2'b0, bcpe_pkg::LOG2E_Q30};
      end
      S_EXPT: begin
        mul_req.en = 1'b1;
        mul_req.a  = {7'b0, prod[55:30]};
        mul_req.b  = {3'b0, bcpe_pkg::LN2_Q30};
      end
      S_HMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {3'b0, t_q};
        mul_req.b  = {2'b0, p_q};
      end
      S_HREC: begin
        mul_req.en = 1'b1;
        mul_req.a  = {2'b0, prod[60:30]};
        mul_req.b  = {1'b0, bcpe_pkg::recip(n_q)};
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (smp_i.valid) state_d = S_MUL;
      S_MUL:    state_d = S_ADD;
      S_ADD:    state_d = last_step ? S_EXPY : S_IDLE;
      S_EXPY:   state_d = S_EXPT;
      S_EXPT:   state_d = S_TSAVE;
      S_TSAVE:  state_d = S_HMUL;
      S_HMUL:   state_d = S_HREC;
      S_HREC:   state_d = S_HFIX;
      S_HFIX:   state_d = (n_q == 4'd1) ? S_FINISH : S_HMUL;
      S_FINISH: state_d = S_ACC;
      S_ACC:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign smp_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      start_q    <= bcpe_pkg::RST_START_LOG_PRICE;
      strike_q   <= bcpe_pkg::RST_STRIKE;
      barrier_q  <= bcpe_pkg::RST_LOG_BARRIER;
      drift_q    <= bcpe_pkg::RST_DRIFT_PER_STEP;
      vol_q      <= bcpe_pkg::RST_VOL_PER_STEP;
      steps_q    <= bcpe_pkg::RST_STEPS_PER_PATH;
      step_q     <= '0;
      knock_q    <= 1'b0;
      sum_all_q  <= '0;
      sum_surv_q <= '0;
      paths_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bcpe_pkg::REG_START_LOG_PRICE: start_q   <= cfg_data_i;
          bcpe_pkg::REG_STRIKE:          strike_q  <= cfg_data_i;
          bcpe_pkg::REG_LOG_BARRIER:     barrier_q <= cfg_data_i;
          bcpe_pkg::REG_DRIFT_PER_STEP:  drift_q   <= cfg_data_i;
          bcpe_pkg::REG_VOL_PER_STEP:    vol_q     <= cfg_data_i[30:0];
          bcpe_pkg::REG_STEPS_PER_PATH:  steps_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (state_q == S_ADD) begin
        knock_q <= knock_d;
        step_q  <= last_step ? 16'd0 : step_q + 16'd1;
      end

      if (out_load) begin
        sum_all_q  <= all_d;
        sum_surv_q <= surv_d;
        if (paths_q != 32'hFFFF_FFFF) begin
          paths_q <= paths_q + 32'd1;
        end
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (smp_i.valid && smp_i.ready) begin
      z_q <= smp_i.normal_sample;
    end
    if (state_q == S_ADD) begin
      lp_q <= next_lp;
    end
    if (state_q == S_EXPT) begin
      k_q <= $signed(prod[63:56]);
    end
    if (state_q == S_TSAVE) begin
      t_q <= prod[55:26];
      p_q <= bcpe_pkg::ONE_Q30;
      n_q <= bcpe_pkg::HORNER_N0;
    end
    if (state_q == S_HREC) begin
      q_q <= prod[60:30];
    end
    if (state_q == S_HFIX) begin
      p_q <= bcpe_pkg::ONE_Q30 + quot;
      n_q <= n_q - 4'd1;
    end
    if (state_q == S_FINISH) begin
      pay_q <= (price > strike_q) ? price - strike_q : 32'd0;
    end
    if (out_load) begin
      out_pay_q   <= pay_q;
      out_knock_q <= knock_q;
      out_all_q   <= all_d;
      out_surv_q  <= surv_d;
      out_paths_q <= (paths_q != 32'hFFFF_FFFF) ? paths_q + 32'd1 : paths_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.payoff          = out_pay_q;
  assign res_o.was_knocked_out = out_knock_q;
  assign res_o.plain_total     = out_all_q;
  assign res_o.barrier_total   = out_surv_q;
  assign res_o.paths_done      = out_paths_q;

  // Survivor sum never exceeds the plain sum
  a_surv_le_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_surv_q <= sum_all_q)
    else $error("survivor sum above plain sum");

  // Reciprocal estimate leaves a remainder below twice the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HFIX) |-> (rem < {30'b0, n_q, 1'b0}))
    else $error("horner quotient correction out of range");

  // Horner divisor stays within 1..9 while iterating
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HMUL || state_q == S_HREC || state_q == S_HFIX) |->
    (n_q >= 4'd1 && n_q <= bcpe_pkg::HORNER_N0))
    else $error("horner divisor out of range");

  // A knocked-out path leaves the survivor sum untouched
  a_knock_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && knock_q) |=> $stable(sum_surv_q))
    else $error("knocked-out path reached survivor sum");

  // A finished beat carries a payoff no larger than the plain total
  a_pay_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ({32'b0, res_o.payoff} <= res_o.plain_total))
    else $error("payoff above plain total");

endmodule
